[hw/rtl/tccw_pkg.sv]
// Shared constants, types and the cell address helper function of the text console writer.
package tccw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int NCELLS  = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(NCELLS);
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int REG_W  = 16;

  localparam logic [ADDR_W-1:0] COPY_START = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] BLANK_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] BLANK_ROW  = ADDR_W'((ROWS - 2) * COLUMNS);
  localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(NCELLS - 1);

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [7:0] TEXT_ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] cell_data;
  } res_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

[hw/rtl/text_console_char_writer.sv]
// Top level of the text console writer: attribute register, result register and checks.
// The block keeps an 80x25 store of 16-bit cells (attribute high byte, character low
// byte) in one memory with one write and one registered read port, and a cursor. After
// reset it first zeroes all 2000 cells, one per cycle, and accepts no word meanwhile.
// It then handles one request word at a time: a read inside the store reads its cell, a
// printable character writes its cell, a backspace blanks the previous character, a CR,
// an LF or a backspace at column 0 writes no cell, a read outside the store or an
// unused request type only answers, a clear blanks one cell per cycle over rows 0 to
// 23, and a character that makes the screen scroll adds the row copy and blanking the
// new line, all paced by the single cell address counter. The result word is held in an
// output register, so a new request can be taken while it waits.
module text_console_char_writer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        text_attr_we_i,
  input  logic [7:0]                  text_attr_i,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic [7:0]                  char_code_i,
  input  logic [tccw_pkg::IDX_W-1:0]  cell_index_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output logic [tccw_pkg::COL_W-1:0]  cursor_col_o,
  output logic [tccw_pkg::ROW_W-1:0]  cursor_row_o,
  output logic [tccw_pkg::REG_W-1:0]  cursor_reg_o,
  output logic [7:0]                  cell_char_o,
  output logic [7:0]                  cell_attr_o
);

  logic                        attr_we;
  logic [7:0]                  text_attr_q;
  tccw_pkg::mem_req_t          mem_req;
  logic [tccw_pkg::CELL_W-1:0] mem_rdata;
  logic                        res_valid;
  tccw_pkg::res_t              res;
  logic                        res_take;
  logic                        out_valid_q;
  logic [tccw_pkg::COL_W-1:0]  col_q;
  logic [tccw_pkg::ROW_W-1:0]  row_q;
  logic [tccw_pkg::REG_W-1:0]  reg_q;
  logic [tccw_pkg::CELL_W-1:0] cell_q;

  assign attr_we = text_attr_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= tccw_pkg::TEXT_ATTR_RESET;
    end else if (attr_we) begin
      text_attr_q <= text_attr_i;
    end
  end

  tccw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_ready_o  (req_ready_o),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .text_attr_i  (text_attr_q),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_take_i   (res_take),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  tccw_cell_ram u_ram (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  assign res_take = res_valid && (!out_valid_q || rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      col_q  <= res.col;
      row_q  <= res.row;
      reg_q  <= tccw_pkg::REG_W'(res.row) * tccw_pkg::REG_W'(tccw_pkg::COLUMNS)
                + tccw_pkg::REG_W'(res.col) - tccw_pkg::REG_W'(1);
      cell_q <= res.cell_data;
    end
  end

  assign rsp_valid_o  = out_valid_q;
  assign cursor_col_o = col_q;
  assign cursor_row_o = row_q;
  assign cursor_reg_o = reg_q;
  assign cell_char_o  = cell_q[7:0];
  assign cell_attr_o  = cell_q[15:8];

  // One request word is handled at a time, so an accept is never followed by another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o)
    else $error("request accepted while a request was in progress");

  // The cursor reported after any request lies above the bottom line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> ((cursor_col_o < tccw_pkg::COL_W'(tccw_pkg::COLUMNS)) &&
                     (cursor_row_o < tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1))))
    else $error("reported cursor outside the screen");

  // A result only enters the output register when the previous one has been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |-> !res_take)
    else $error("result register overwritten while waiting");

endmodule

[hw/rtl/tccw_cell_ram.sv]
// Single-port-write, single-read cell store with registered read data.
module tccw_cell_ram (
  input  logic                     clk_i,
  input  tccw_pkg::mem_req_t       mem_req_i,
  output logic [tccw_pkg::CELL_W-1:0] rdata_o
);

  logic [tccw_pkg::CELL_W-1:0] mem_q [tccw_pkg::NCELLS];
  logic [tccw_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    rdata_q <= mem_q[mem_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tccw_ctrl.sv]
// Sequencer of the text console writer: cursor, address counter and cell store traffic.
module tccw_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic [7:0]                  char_code_i,
  input  logic [tccw_pkg::IDX_W-1:0]  cell_index_i,
  input  logic [7:0]                  text_attr_i,
  output logic                        res_valid_o,
  output tccw_pkg::res_t              res_o,
  input  logic                        res_take_i,
  output tccw_pkg::mem_req_t          mem_req_o,
  input  logic [tccw_pkg::CELL_W-1:0] mem_rdata_i
);

  localparam logic [3:0] S_FILL   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_RDCAP  = 4'd3;
  localparam logic [3:0] S_BS_RD  = 4'd4;
  localparam logic [3:0] S_BS_WR  = 4'd5;
  localparam logic [3:0] S_PUT_WR = 4'd6;
  localparam logic [3:0] S_CHK    = 4'd7;
  localparam logic [3:0] S_COPY   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]                    state_q, state_d;
  logic [tccw_pkg::ADDR_W-1:0]   cnt_q, cnt_d;
  logic [tccw_pkg::ADDR_W-1:0]   fill_end_q, fill_end_d;
  logic [tccw_pkg::CELL_W-1:0]   fill_val_q, fill_val_d;
  logic                          fill_init_q, fill_init_d;
  logic [tccw_pkg::COL_W-1:0]    col_q, col_d;
  logic [tccw_pkg::ROW_W-1:0]    row_q, row_d;
  logic [tccw_pkg::CELL_W-1:0]   cell_q, cell_d;
  logic [tccw_pkg::ADDR_W-1:0]   cnt_inc;

  assign cnt_inc = cnt_q + tccw_pkg::ADDR_W'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fill_end_d  = fill_end_q;
    fill_val_d  = fill_val_q;
    fill_init_d = fill_init_q;
    col_d       = col_q;
    row_d       = row_q;
    cell_d      = cell_q;
    unique case (state_q)
      S_FILL: begin
        if (cnt_q == fill_end_q) begin
          state_d = fill_init_q ? S_IDLE : S_DONE;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cell_d = '0;
          unique case (req_type_i)
            tccw_pkg::REQ_PUT: begin
              state_d = S_CHK;
              if (char_code_i == tccw_pkg::CH_BS) begin
                if (col_q != '0) begin
                  col_d   = col_q - tccw_pkg::COL_W'(1);
                  cnt_d   = tccw_pkg::cell_addr(row_q, col_q - tccw_pkg::COL_W'(1));
                  state_d = S_BS_RD;
                end
              end else if (char_code_i == tccw_pkg::CH_CR) begin
                col_d = '0;
              end else if (char_code_i == tccw_pkg::CH_LF) begin
                col_d = '0;
                row_d = row_q + tccw_pkg::ROW_W'(1);
              end else begin
                cnt_d      = tccw_pkg::cell_addr(row_q, col_q);
                fill_val_d = {text_attr_i, char_code_i};
                state_d    = S_PUT_WR;
                if (col_q == tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1)) begin
                  col_d = '0;
                  row_d = row_q + tccw_pkg::ROW_W'(1);
                end else begin
                  col_d = col_q + tccw_pkg::COL_W'(1);
                end
              end
            end
            tccw_pkg::REQ_CLEAR: begin
              col_d       = '0;
              row_d       = '0;
              cnt_d       = '0;
              fill_end_d  = tccw_pkg::BLANK_LAST;
              fill_val_d  = {text_attr_i, 8'h00};
              fill_init_d = 1'b0;
              state_d     = S_FILL;
            end
            tccw_pkg::REQ_READ: begin
              if (cell_index_i < tccw_pkg::IDX_W'(tccw_pkg::NCELLS)) begin
                cnt_d   = tccw_pkg::ADDR_W'(cell_index_i);
                state_d = S_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_RDCAP;
      end
      S_RDCAP: begin
        cell_d  = mem_rdata_i;
        state_d = S_DONE;
      end
      S_BS_RD: begin
        state_d = S_BS_WR;
      end
      S_BS_WR: begin
        state_d = S_CHK;
      end
      S_PUT_WR: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (row_q >= tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1)) begin
          row_d   = row_q - tccw_pkg::ROW_W'(1);
          cnt_d   = tccw_pkg::COPY_START;
          state_d = S_COPY;
        end else begin
          state_d = S_DONE;
        end
      end
      S_COPY: begin
        if (cnt_q == tccw_pkg::COPY_END) begin
          cnt_d       = tccw_pkg::BLANK_ROW;
          fill_end_d  = tccw_pkg::BLANK_LAST;
          fill_val_d  = {text_attr_i, 8'h00};
          fill_init_d = 1'b0;
          state_d     = S_FILL;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = cnt_q;
    mem_req_o.wdata = fill_val_q;
    mem_req_o.raddr = cnt_q;
    unique case (state_q)
      S_FILL, S_PUT_WR: begin
        mem_req_o.we = 1'b1;
      end
      S_BS_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.wdata = {mem_rdata_i[15:8], 8'h00};
      end
      S_COPY: begin
        mem_req_o.we    = (cnt_q != tccw_pkg::COPY_START);
        mem_req_o.waddr = cnt_q - tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS + 1);
        mem_req_o.wdata = mem_rdata_i;
      end
      default: begin
        mem_req_o.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      cnt_q       <= '0;
      fill_end_q  <= tccw_pkg::CELL_LAST;
      fill_val_q  <= '0;
      fill_init_q <= 1'b1;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_end_q  <= fill_end_d;
      fill_val_q  <= fill_val_d;
      fill_init_q <= fill_init_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign req_ready_o     = (state_q == S_IDLE);
  assign res_valid_o     = (state_q == S_DONE);
  assign res_o.col       = col_q;
  assign res_o.row       = row_q;
  assign res_o.cell_data = cell_q;

endmodule
